>>> design/fwsc_pkg.sv
// Shared types, constants and helper functions for the follow wheel speed control block.
// Depends on nothing; every other design file refers to it by scoped names.
package fwsc_pkg;

   // Wheel track of the robot in mm; the turn rate is scaled by 1000 over this track.
   localparam int WHEEL_TRACK_MM = 540;
   localparam int RATE_SCALE     = 1000;
   // Half width of the following band around the follow center, in mm.
   localparam int BAND_MM        = 200;

   localparam logic signed [15:0] TURN_RESET     = 16'sd300;
   localparam logic signed [15:0] STRAIGHT_RESET = 16'sd500;

   // Shared divider: 32-bit dividend, 17-bit divisor, two quotient bits per cycle.
   localparam int DIVIDEND_W = 32;
   localparam int DIVISOR_W  = 17;
   localparam int DIV_STEPS  = DIVIDEND_W / 2;
   localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

   // Turn rate limits for the 18-bit signed result.
   localparam int RATE_W = 18;
   localparam logic [DIVIDEND_W-1:0] RATE_POS_LIMIT = DIVIDEND_W'((1 << (RATE_W - 1)) - 1);
   localparam logic [DIVIDEND_W-1:0] RATE_NEG_LIMIT = DIVIDEND_W'(1 << (RATE_W - 1));
   localparam logic [RATE_W-1:0]     RATE_MAX       = RATE_W'((1 << (RATE_W - 1)) - 1);
   localparam logic [RATE_W-1:0]     RATE_MIN       = RATE_W'(1 << (RATE_W - 1));

   // Register file port.
   localparam int ADDR_W = 5;
   localparam int DATA_W = 32;

   localparam logic [2:0] REG_DISTANCE_LIMIT   = 3'd0;
   localparam logic [2:0] REG_FOLLOW_CENTER    = 3'd1;
   localparam logic [2:0] REG_STOP_DISTANCE    = 3'd2;
   localparam logic [2:0] REG_ROBOT_HALF_WIDTH = 3'd3;
   localparam logic [2:0] REG_LATERAL_MARGIN   = 3'd4;
   localparam logic [2:0] REG_LINE_STEP        = 3'd5;
   localparam logic [2:0] REG_TURN_STEP        = 3'd6;
   localparam logic [2:0] REG_CRUISE_SPEED     = 3'd7;

   typedef struct packed {
      logic [15:0] distance_limit;
      logic [15:0] follow_center;
      logic [15:0] stop_distance;
      logic [14:0] robot_half_width;
      logic [14:0] lateral_margin;
      logic [14:0] line_step;
      logic [14:0] turn_step;
      logic [14:0] cruise_speed;
   } cfg_type;

   typedef struct packed {
      logic                  start;
      logic [DIVIDEND_W-1:0] dividend;
      logic [DIVISOR_W-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic                  busy;
      logic                  done;
      logic [DIVIDEND_W-1:0] quotient;
   } div_rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_MUL,
      ST_STEP_DIV,
      ST_EMIT_PREP,
      ST_EMIT_DIV,
      ST_EMIT_OUT
   } state_type;

   typedef enum logic [1:0] {
      OP_FAR,
      OP_NEAR,
      OP_TURN
   } op_type;

   // Clamp a wide signed value to the signed 16-bit range.
   function automatic logic signed [15:0] sat16(input logic signed [32:0] v);
      if (v > 33'sd32767) begin
         return 16'sh7FFF;
      end
      if (v < -33'sd32768) begin
         return 16'sh8000;
      end
      return v[15:0];
   endfunction

   // Halve a signed 16-bit value, rounding toward zero.
   function automatic logic signed [15:0] half16(input logic signed [15:0] v);
      logic signed [15:0] adj;
      adj = v + {15'd0, v[15]};
      return adj >>> 1;
   endfunction

endpackage

>>> design/fwsc_csr.sv
// Configuration register file with an APB-style write and read port.
// Depends on fwsc_pkg for the register indexes and the configuration struct.
module fwsc_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [fwsc_pkg::ADDR_W-1:0]  paddr,
   input  logic [fwsc_pkg::DATA_W-1:0]  pwdata,
   output logic [fwsc_pkg::DATA_W-1:0]  prdata,
   output logic                         pready,
   output fwsc_pkg::cfg_type            cfg
);

   fwsc_pkg::cfg_type cfg_ff;
   fwsc_pkg::cfg_type cfg_in;
   logic [2:0]        reg_index;
   logic              wr_en;

   assign reg_index = paddr[fwsc_pkg::ADDR_W-1:2];
   assign wr_en     = psel & penable & pwrite;
   assign pready    = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_index)
            fwsc_pkg::REG_DISTANCE_LIMIT:   cfg_in.distance_limit   = pwdata[15:0];
            fwsc_pkg::REG_FOLLOW_CENTER:    cfg_in.follow_center    = pwdata[15:0];
            fwsc_pkg::REG_STOP_DISTANCE:    cfg_in.stop_distance    = pwdata[15:0];
            fwsc_pkg::REG_ROBOT_HALF_WIDTH: cfg_in.robot_half_width = pwdata[14:0];
            fwsc_pkg::REG_LATERAL_MARGIN:   cfg_in.lateral_margin   = pwdata[14:0];
            fwsc_pkg::REG_LINE_STEP:        cfg_in.line_step        = pwdata[14:0];
            fwsc_pkg::REG_TURN_STEP:        cfg_in.turn_step        = pwdata[14:0];
            fwsc_pkg::REG_CRUISE_SPEED:     cfg_in.cruise_speed     = pwdata[14:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         fwsc_pkg::REG_DISTANCE_LIMIT:   prdata = {16'd0, cfg_ff.distance_limit};
         fwsc_pkg::REG_FOLLOW_CENTER:    prdata = {16'd0, cfg_ff.follow_center};
         fwsc_pkg::REG_STOP_DISTANCE:    prdata = {16'd0, cfg_ff.stop_distance};
         fwsc_pkg::REG_ROBOT_HALF_WIDTH: prdata = {17'd0, cfg_ff.robot_half_width};
         fwsc_pkg::REG_LATERAL_MARGIN:   prdata = {17'd0, cfg_ff.lateral_margin};
         fwsc_pkg::REG_LINE_STEP:        prdata = {17'd0, cfg_ff.line_step};
         fwsc_pkg::REG_TURN_STEP:        prdata = {17'd0, cfg_ff.turn_step};
         fwsc_pkg::REG_CRUISE_SPEED:     prdata = {17'd0, cfg_ff.cruise_speed};
         default:                        prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{distance_limit:   16'd4000,
                     follow_center:    16'd1500,
                     stop_distance:    16'd900,
                     robot_half_width: 15'd300,
                     lateral_margin:   15'd0,
                     line_step:        15'd50,
                     turn_step:        15'd30,
                     cruise_speed:     15'd500};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

>>> design/fwsc_divider.sv
// Shared iterative unsigned divider, two restoring steps per cycle.
// Depends on fwsc_pkg for widths and the request and response structs.
module fwsc_divider (
   input  logic                  clock,
   input  logic                  reset,
   input  fwsc_pkg::div_req_type req,
   output fwsc_pkg::div_rsp_type rsp
);

   logic [fwsc_pkg::DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [fwsc_pkg::DIVISOR_W-1:0]  div_ff, div_in;
   logic [fwsc_pkg::DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [fwsc_pkg::DIV_CNT_W-1:0]  cnt_ff, cnt_in;
   logic                            busy_ff, busy_in;
   logic                            done_ff, done_in;

   logic [fwsc_pkg::DIVISOR_W:0]    trial_a, trial_b;
   logic [fwsc_pkg::DIVISOR_W:0]    diff_a, diff_b;
   logic [fwsc_pkg::DIVISOR_W-1:0]  rem_mid, rem_next;
   logic                            bit_a, bit_b;

   always_comb begin
      // First step consumes the top dividend bit, the second the next one.
      trial_a  = {rem_ff, quo_ff[fwsc_pkg::DIVIDEND_W-1]};
      diff_a   = trial_a - {1'b0, div_ff};
      bit_a    = (trial_a >= {1'b0, div_ff});
      rem_mid  = bit_a ? diff_a[fwsc_pkg::DIVISOR_W-1:0] : trial_a[fwsc_pkg::DIVISOR_W-1:0];
      trial_b  = {rem_mid, quo_ff[fwsc_pkg::DIVIDEND_W-2]};
      diff_b   = trial_b - {1'b0, div_ff};
      bit_b    = (trial_b >= {1'b0, div_ff});
      rem_next = bit_b ? diff_b[fwsc_pkg::DIVISOR_W-1:0] : trial_b[fwsc_pkg::DIVISOR_W-1:0];

      rem_in  = rem_ff;
      div_in  = div_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;

      if (req.start) begin
         rem_in  = '0;
         div_in  = req.divisor;
         quo_in  = req.dividend;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = rem_next;
         quo_in = {quo_ff[fwsc_pkg::DIVIDEND_W-3:0], bit_a, bit_b};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == fwsc_pkg::DIV_CNT_W'(fwsc_pkg::DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      div_ff <= div_in;
      quo_ff <= quo_in;
   end

   assign rsp.busy     = busy_ff;
   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

endmodule

>>> design/follow_wheel_speed_control.sv
// Leader-following wheel speed controller: one request at a time, one shared divider.
// Per request: no result at or beyond the distance limit, one result off centre, and two
// centred (straight pair, then turning pair), with or without a step division first.
// Every division runs in the radix-4 shared divider, and output stalls hold the sequencer.
// The next request is taken only once the last result of the previous one is loaded.
// Synchronous reset restores the register defaults and the wheel speeds; no clearing pass.
module follow_wheel_speed_control (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [15:0]                  req_leader_distance,
   input  logic signed [15:0]           req_lateral_offset,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [15:0]           rsp_linear_speed,
   output logic signed [17:0]           rsp_turn_rate,
   output logic                         rsp_from_turn_pair,
   output logic                         rsp_last,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [fwsc_pkg::ADDR_W-1:0]  paddr,
   input  logic [fwsc_pkg::DATA_W-1:0]  pwdata,
   output logic [fwsc_pkg::DATA_W-1:0]  prdata,
   output logic                         pready
);

   fwsc_pkg::cfg_type     cfg;
   fwsc_pkg::div_req_type div_req;
   fwsc_pkg::div_rsp_type div_rsp;

   // Sequencer and request registers.
   fwsc_pkg::state_type   state_ff, state_in;
   fwsc_pkg::op_type      op_ff, op_in;
   logic [15:0]           dist_ff, dist_in;
   logic signed [15:0]    offs_ff, offs_in;
   logic [14:0]           mul_a_ff, mul_a_in;
   logic [15:0]           mul_b_ff, mul_b_in;
   logic [16:0]           divisor_ff, divisor_in;

   // Wheel speed state in mm/s.
   logic signed [15:0]    sl_ff, sl_in;
   logic signed [15:0]    sr_ff, sr_in;
   logic signed [15:0]    tl_ff, tl_in;
   logic signed [15:0]    tr_ff, tr_in;

   // Result being built and the output register.
   logic                  emit_turn_ff, emit_turn_in;
   logic                  emit_last_ff, emit_last_in;
   logic signed [15:0]    lin_ff, lin_in;
   logic                  rate_neg_ff, rate_neg_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic signed [15:0]    lin_out_ff, lin_out_in;
   logic [17:0]           rate_out_ff, rate_out_in;
   logic                  turn_out_ff, turn_out_in;
   logic                  last_out_ff, last_out_in;

   // Decision terms.
   logic [15:0]           ax;
   logic [15:0]           thr;
   logic [16:0]           far_mm;
   logic signed [16:0]    near_mm;
   logic [14:0]           hw_div;
   logic                  centred;

   // Step application and result terms.
   logic signed [32:0]    step_q;
   logic signed [32:0]    sl_ext, sr_ext, tl_ext, tr_ext;
   logic signed [15:0]    pair_l, pair_r;
   logic signed [16:0]    pair_sum, pair_adj, pair_diff;
   logic [16:0]           diff_mag;
   logic [17:0]           rate_val;
   logic                  slot_free;

   fwsc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   fwsc_divider u_divider (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // A request is only taken while the sequencer is idle; the output register lets
   // the next request in even while the final result of the previous one still waits.
   assign req_stall = reset | (state_ff != fwsc_pkg::ST_IDLE);
   assign slot_free = ~rsp_valid_ff | ~rsp_stall;

   always_comb begin
      // The leader offset magnitude; the most negative offset maps to 32768.
      ax      = offs_ff[15] ? (~offs_ff + 16'd1) : offs_ff;
      thr     = {1'b0, cfg.robot_half_width} + {1'b0, cfg.lateral_margin};
      centred = (ax <= thr);
      far_mm  = {1'b0, cfg.follow_center} + 17'(fwsc_pkg::BAND_MM);
      near_mm = $signed({1'b0, cfg.follow_center}) - 17'(fwsc_pkg::BAND_MM);
      hw_div  = (cfg.robot_half_width == 15'd0) ? 15'd1 : cfg.robot_half_width;

      // The quotient never exceeds 31 bits, so it is a positive step.
      step_q = $signed({1'b0, div_rsp.quotient});
      sl_ext = $signed({{17{sl_ff[15]}}, sl_ff});
      sr_ext = $signed({{17{sr_ff[15]}}, sr_ff});
      tl_ext = $signed({{17{tl_ff[15]}}, tl_ff});
      tr_ext = $signed({{17{tr_ff[15]}}, tr_ff});

      // The pair that the next result is computed from.
      pair_l    = emit_turn_ff ? tl_ff : sl_ff;
      pair_r    = emit_turn_ff ? tr_ff : sr_ff;
      pair_sum  = $signed({pair_l[15], pair_l}) + $signed({pair_r[15], pair_r});
      pair_adj  = pair_sum + {16'd0, pair_sum[16]};
      pair_diff = $signed({pair_r[15], pair_r}) - $signed({pair_l[15], pair_l});
      diff_mag  = pair_diff[16] ? 17'(-pair_diff) : 17'(pair_diff);

      // The turn rate magnitude comes out of the divider; restore the sign and clamp.
      if (rate_neg_ff) begin
         rate_val = (div_rsp.quotient > fwsc_pkg::RATE_NEG_LIMIT) ? fwsc_pkg::RATE_MIN
                  : 18'(18'd0 - div_rsp.quotient[17:0]);
      end else begin
         rate_val = (div_rsp.quotient > fwsc_pkg::RATE_POS_LIMIT) ? fwsc_pkg::RATE_MAX
                  : div_rsp.quotient[17:0];
      end

      state_in     = state_ff;
      op_in        = op_ff;
      dist_in      = dist_ff;
      offs_in      = offs_ff;
      mul_a_in     = mul_a_ff;
      mul_b_in     = mul_b_ff;
      divisor_in   = divisor_ff;
      sl_in        = sl_ff;
      sr_in        = sr_ff;
      tl_in        = tl_ff;
      tr_in        = tr_ff;
      emit_turn_in = emit_turn_ff;
      emit_last_in = emit_last_ff;
      lin_in       = lin_ff;
      rate_neg_in  = rate_neg_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      lin_out_in   = lin_out_ff;
      rate_out_in  = rate_out_ff;
      turn_out_in  = turn_out_ff;
      last_out_in  = last_out_ff;

      div_req.start    = 1'b0;
      div_req.dividend = '0;
      div_req.divisor  = divisor_ff;

      case (state_ff)
         fwsc_pkg::ST_IDLE: begin
            if (req_valid && !req_stall) begin
               dist_in  = req_leader_distance;
               offs_in  = req_lateral_offset;
               state_in = fwsc_pkg::ST_DECIDE;
            end
         end

         fwsc_pkg::ST_DECIDE: begin
            if (dist_ff >= cfg.distance_limit) begin
               // Leader lost or too far: stop straight motion, nothing is reported.
               sl_in    = '0;
               sr_in    = '0;
               state_in = fwsc_pkg::ST_IDLE;
            end else if (centred) begin
               emit_turn_in = 1'b0;
               emit_last_in = 1'b0;
               if ({1'b0, dist_ff} > far_mm) begin
                  op_in      = fwsc_pkg::OP_FAR;
                  mul_a_in   = cfg.line_step;
                  mul_b_in   = dist_ff;
                  divisor_in = far_mm;
                  state_in   = fwsc_pkg::ST_MUL;
               end else if ($signed({1'b0, dist_ff}) >= near_mm) begin
                  sl_in    = $signed({1'b0, cfg.cruise_speed});
                  sr_in    = $signed({1'b0, cfg.cruise_speed});
                  state_in = fwsc_pkg::ST_EMIT_PREP;
               end else if (dist_ff > cfg.stop_distance) begin
                  // Here the near edge is positive and the distance at least one.
                  op_in      = fwsc_pkg::OP_NEAR;
                  mul_a_in   = cfg.line_step;
                  mul_b_in   = near_mm[15:0];
                  divisor_in = {1'b0, dist_ff};
                  state_in   = fwsc_pkg::ST_MUL;
               end else begin
                  sl_in    = '0;
                  sr_in    = '0;
                  state_in = fwsc_pkg::ST_EMIT_PREP;
               end
            end else begin
               emit_turn_in = 1'b1;
               emit_last_in = 1'b1;
               op_in        = fwsc_pkg::OP_TURN;
               mul_a_in     = cfg.turn_step;
               mul_b_in     = ax;
               divisor_in   = {2'b00, hw_div};
               state_in     = fwsc_pkg::ST_MUL;
            end
         end

         fwsc_pkg::ST_MUL: begin
            // The product is captured by the divider's dividend register.
            div_req.start    = 1'b1;
            div_req.dividend = {17'd0, mul_a_ff} * {16'd0, mul_b_ff};
            state_in         = fwsc_pkg::ST_STEP_DIV;
         end

         fwsc_pkg::ST_STEP_DIV: begin
            if (div_rsp.done) begin
               case (op_ff)
                  fwsc_pkg::OP_FAR: begin
                     sl_in = fwsc_pkg::sat16(sl_ext + step_q);
                     sr_in = fwsc_pkg::sat16(sr_ext + step_q);
                  end
                  fwsc_pkg::OP_NEAR: begin
                     sl_in = fwsc_pkg::sat16(sl_ext - step_q);
                     sr_in = fwsc_pkg::sat16(sr_ext - step_q);
                  end
                  fwsc_pkg::OP_TURN: begin
                     // Steer toward the leader; a straight wheel on that side that is not moving forward
                     // picks up half the speed of the other one.
                     if (offs_ff[15]) begin
                        tl_in = fwsc_pkg::sat16(tl_ext - step_q);
                        tr_in = fwsc_pkg::sat16(tr_ext + step_q);
                        if (!(sl_ff > 16'sd0)) begin
                           sl_in = fwsc_pkg::half16(sr_ff);
                        end
                     end else begin
                        tl_in = fwsc_pkg::sat16(tl_ext + step_q);
                        tr_in = fwsc_pkg::sat16(tr_ext - step_q);
                        if (!(sr_ff > 16'sd0)) begin
                           sr_in = fwsc_pkg::half16(sl_ff);
                        end
                     end
                  end
                  default: begin
                  end
               endcase
               state_in = fwsc_pkg::ST_EMIT_PREP;
            end
         end

         fwsc_pkg::ST_EMIT_PREP: begin
            // Mean speed is a halving; the turn rate needs a division by the track.
            lin_in           = 16'(pair_adj >>> 1);
            rate_neg_in      = pair_diff[16];
            div_req.start    = 1'b1;
            div_req.dividend = {15'd0, diff_mag} * fwsc_pkg::DIVIDEND_W'(fwsc_pkg::RATE_SCALE);
            div_req.divisor  = fwsc_pkg::DIVISOR_W'(fwsc_pkg::WHEEL_TRACK_MM);
            state_in         = fwsc_pkg::ST_EMIT_DIV;
         end

         fwsc_pkg::ST_EMIT_DIV: begin
            if (div_rsp.done) begin
               state_in = fwsc_pkg::ST_EMIT_OUT;
            end
         end

         fwsc_pkg::ST_EMIT_OUT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               lin_out_in   = lin_ff;
               rate_out_in  = rate_val;
               turn_out_in  = emit_turn_ff;
               last_out_in  = emit_last_ff;
               if (emit_last_ff) begin
                  state_in = fwsc_pkg::ST_IDLE;
               end else begin
                  // After the straight pair, the turning pair is recentred and reported.
                  tl_in        = fwsc_pkg::TURN_RESET;
                  tr_in        = fwsc_pkg::TURN_RESET;
                  emit_turn_in = 1'b1;
                  emit_last_in = 1'b1;
                  state_in     = fwsc_pkg::ST_EMIT_PREP;
               end
            end
         end

         default: begin
            state_in = fwsc_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fwsc_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         sl_ff        <= fwsc_pkg::STRAIGHT_RESET;
         sr_ff        <= fwsc_pkg::STRAIGHT_RESET;
         tl_ff        <= fwsc_pkg::TURN_RESET;
         tr_ff        <= fwsc_pkg::TURN_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         sl_ff        <= sl_in;
         sr_ff        <= sr_in;
         tl_ff        <= tl_in;
         tr_ff        <= tr_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      dist_ff      <= dist_in;
      offs_ff      <= offs_in;
      mul_a_ff     <= mul_a_in;
      mul_b_ff     <= mul_b_in;
      divisor_ff   <= divisor_in;
      emit_turn_ff <= emit_turn_in;
      emit_last_ff <= emit_last_in;
      lin_ff       <= lin_in;
      rate_neg_ff  <= rate_neg_in;
      lin_out_ff   <= lin_out_in;
      rate_out_ff  <= rate_out_in;
      turn_out_ff  <= turn_out_in;
      last_out_ff  <= last_out_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_linear_speed   = lin_out_ff;
   assign rsp_turn_rate      = $signed(rate_out_ff);
   assign rsp_from_turn_pair = turn_out_ff;
   assign rsp_last           = last_out_ff;

   // The divider only finishes while the sequencer is waiting for it.
   assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == fwsc_pkg::ST_STEP_DIV || state_ff == fwsc_pkg::ST_EMIT_DIV))
      else $error("divider finished outside a wait state");

   // A new request is never taken while a division is still running.
   assert property (@(posedge clock) disable iff (reset)
      !req_stall |-> !div_rsp.busy)
      else $error("request port open while the divider is busy");

   // A turning-pair result is always the final one of its request.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last || !rsp_from_turn_pair))
      else $error("turning-pair result not marked as final");

   // Loading the output register shows the result with the expected final flag.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == fwsc_pkg::ST_EMIT_OUT && slot_free)
      |=> (rsp_valid_ff && (last_out_ff == $past(emit_last_ff))))
      else $error("result not loaded into the output register");

endmodule
